// File: rtl/cursor_list_of_handles_macros.svh
// ----------------------------------------------------------------------------
// cursor_list_of_handles_macros
// Assertion macros used by the cursor list sequencer (cloh_ctrl).
// ----------------------------------------------------------------------------
`ifndef CURSOR_LIST_OF_HANDLES_MACROS_SVH
`define CURSOR_LIST_OF_HANDLES_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define CLOH_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define CLOH_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/cloh_pkg.sv
// ----------------------------------------------------------------------------
// cloh_pkg
// Shared constants, codes and types of the cursor list of handles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cloh_pkg;

    // Default configuration
    localparam int CAPACITY_DEF    = 256;
    localparam int HANDLE_BITS_DEF = 32;

    // Field widths on the stream ports
    localparam int ACTION_W   = 4;
    localparam int HANDLE_W   = 32;
    localparam int SEEK_W     = 10;
    localparam int LEN_W      = 9;
    localparam int CUR_W      = 10;
    localparam int STATUS_W   = 2;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 56;

    // Command codes
    localparam logic [ACTION_W-1:0] ACT_INS_BEFORE = 4'd0;
    localparam logic [ACTION_W-1:0] ACT_INS_AFTER  = 4'd1;
    localparam logic [ACTION_W-1:0] ACT_REMOVE     = 4'd2;
    localparam logic [ACTION_W-1:0] ACT_SEEK       = 4'd3;
    localparam logic [ACTION_W-1:0] ACT_ADVANCE    = 4'd4;
    localparam logic [ACTION_W-1:0] ACT_RETREAT    = 4'd5;
    localparam logic [ACTION_W-1:0] ACT_TO_START   = 4'd6;
    localparam logic [ACTION_W-1:0] ACT_TO_END     = 4'd7;
    localparam logic [ACTION_W-1:0] ACT_READ       = 4'd8;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_ITEM = 2'd2;

    // Memory port enables
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

    // One result word
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CUR_W-1:0]    cursor_index;
        logic [LEN_W-1:0]    list_length;
        logic                item_valid;
        logic [HANDLE_W-1:0] handle_out;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/cursor_list_of_handles.sv
// ----------------------------------------------------------------------------
// cursor_list_of_handles
// Ordered list of opaque handles with a cursor, driven by stream commands.
// ----------------------------------------------------------------------------
// One command is in work at a time; each gives one result word. Cursor moves,
// seek, read and failed commands pass through the look and fetch states before
// the result is offered. An insert first shifts the entries at and above the
// slot up, then writes the new handle (the shift is skipped when nothing
// moves); a remove reads the handle under the cursor, then shifts the entries
// above the cursor down. Those entries move one per cycle through the one read
// port and one write port of the handle memory. A finished result waits in the
// output register while the next command is taken. No clearing pass after
// reset.
`timescale 1ns / 1ps
`default_nettype none

module cursor_list_of_handles
    import cloh_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // command stream
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,   // item_handle[31:0], seek_index[41:32]
    input  wire logic [ACTION_W-1:0]  i_s_tuser,   // action[3:0]
    // result stream
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic      [M_TDATA_W-1:0] o_m_tdata    // handle_out[31:0], item_valid[32],
                                                   // list_length[41:33],
                                                   // cursor_index[51:42], status[53:52]
);

    localparam int AW = $clog2(CAPACITY);

    t_mem_ctl               w_mem_ctl;
    logic [AW-1:0]          w_waddr;
    logic [AW-1:0]          w_raddr;
    logic [HANDLE_BITS-1:0] w_wdata;
    logic [HANDLE_BITS-1:0] w_rdata;
    logic                   w_res_valid;
    logic                   w_res_free;
    t_result                w_result;
    logic                   r_m_valid;
    t_result                r_m_word;

    // Handle memory
    cloh_store #(
        .DEPTH (CAPACITY),
        .WIDTH (HANDLE_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_mem_ctl (w_mem_ctl),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr   (w_raddr),
        .o_rdata   (w_rdata)
    );

    // Sequencer
    cloh_ctrl #(
        .CAPACITY    (CAPACITY),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (i_s_tvalid),
        .o_cmd_ready   (o_s_tready),
        .i_action      (i_s_tuser),
        .i_item_handle (i_s_tdata[31:0]),
        .i_seek_index  (i_s_tdata[41:32]),
        .o_mem_ctl     (w_mem_ctl),
        .o_waddr       (w_waddr),
        .o_raddr       (w_raddr),
        .o_wdata       (w_wdata),
        .i_rdata       (w_rdata),
        .o_res_valid   (w_res_valid),
        .i_res_free    (w_res_free),
        .o_result      (w_result)
    );

    // Output register
    assign w_res_free = !r_m_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_res_free) begin
            r_m_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_free && w_res_valid) begin
            r_m_word <= w_result;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {2'b00, r_m_word.status, r_m_word.cursor_index,
                         r_m_word.list_length, r_m_word.item_valid,
                         r_m_word.handle_out};

endmodule

`default_nettype wire

// File: rtl/cloh_store.sv
// ----------------------------------------------------------------------------
// cloh_store
// Handle memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cloh_store
    import cloh_pkg::*;
#(
    parameter  int DEPTH = CAPACITY_DEF,
    parameter  int WIDTH = HANDLE_BITS_DEF,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire t_mem_ctl         i_mem_ctl,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_mem_ctl.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_mem_ctl.rd_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/cloh_ctrl.sv
// ----------------------------------------------------------------------------
// cloh_ctrl
// Command sequencer: cursor and length bookkeeping, and the shift engine that
// moves one stored handle per cycle through a single address stepper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "cursor_list_of_handles_macros.svh"

module cloh_ctrl
    import cloh_pkg::*;
#(
    parameter  int CAPACITY    = CAPACITY_DEF,
    parameter  int HANDLE_BITS = HANDLE_BITS_DEF,
    localparam int AW          = $clog2(CAPACITY)
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // command side
    input  wire logic                   i_cmd_valid,
    output logic                        o_cmd_ready,
    input  wire logic [ACTION_W-1:0]    i_action,
    input  wire logic [HANDLE_W-1:0]    i_item_handle,
    input  wire logic [SEEK_W-1:0]      i_seek_index,
    // memory side
    output t_mem_ctl                    o_mem_ctl,
    output logic      [AW-1:0]          o_waddr,
    output logic      [AW-1:0]          o_raddr,
    output logic      [HANDLE_BITS-1:0] o_wdata,
    input  wire logic [HANDLE_BITS-1:0] i_rdata,
    // result side
    output logic                        o_res_valid,
    input  wire logic                   i_res_free,
    output t_result                     o_result
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = CW + 1;
    localparam int SW = ((KW > SEEK_W) ? KW : SEEK_W) + 1;

    localparam logic signed [KW-1:0] K_ONE  = KW'(1);
    localparam logic signed [KW-1:0] K_NEG1 = '1;

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SHIFT = 3'd1;
    localparam logic [2:0] S_PUT   = 3'd2;
    localparam logic [2:0] S_TAKE  = 3'd3;
    localparam logic [2:0] S_TAKEW = 3'd4;
    localparam logic [2:0] S_LOOK  = 3'd5;
    localparam logic [2:0] S_FETCH = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]              r_state,  n_state;
    logic [CW-1:0]           r_count,  n_count;
    logic signed [KW-1:0]    r_cursor, n_cursor;
    logic [STATUS_W-1:0]     r_status, n_status;
    logic [HANDLE_BITS-1:0]  r_hdl,    n_hdl;
    logic [HANDLE_BITS-1:0]  r_hout,   n_hout;
    logic [AW-1:0]           r_slot,   n_slot;
    logic [AW-1:0]           r_ptr,    n_ptr;
    logic [AW-1:0]           r_last,   n_last;
    logic [AW-1:0]           r_tgt,    n_tgt;
    logic [AW-1:0]           r_wa,     n_wa;
    logic                    r_pend,   n_pend;
    logic                    r_rdone,  n_rdone;
    logic                    r_up,     n_up;

    logic signed [KW-1:0]    w_cnt_s;
    logic                    w_on_item;
    logic                    w_full;
    logic signed [SW-1:0]    w_c_x;
    logic signed [SW-1:0]    w_n_x;
    logic signed [SW-1:0]    w_s_x;
    logic signed [SW-1:0]    w_s_adj;
    logic signed [SW-1:0]    w_seek_x;
    logic signed [KW-1:0]    w_slot_b;
    logic signed [KW-1:0]    w_slot_a;
    logic signed [KW-1:0]    w_slot_k;
    logic signed [KW-1:0]    w_cur_p1_k;
    logic [CW-1:0]           w_cnt_m1;
    logic [AW-1:0]           w_cur_a;
    logic [AW-1:0]           w_step;

    // Cursor and length views
    assign w_cnt_s   = {1'b0, r_count};
    assign w_on_item = !r_cursor[KW-1] && (r_cursor < w_cnt_s);
    assign w_full    = (r_count == CW'(CAPACITY));
    assign w_c_x     = {{(SW-KW){r_cursor[KW-1]}}, r_cursor};
    assign w_n_x     = {{(SW-CW){1'b0}}, r_count};
    assign w_cnt_m1  = r_count - CW'(1);
    assign w_cur_a   = r_cursor[AW-1:0];
    assign w_cur_p1_k = r_cursor + K_ONE;

    // Seek target: negative counts from the end, then clamp
    assign w_s_x    = {{(SW-SEEK_W){i_seek_index[SEEK_W-1]}}, i_seek_index};
    assign w_s_adj  = w_s_x[SW-1] ? (w_s_x + w_n_x) : w_s_x;
    assign w_seek_x = w_s_adj[SW-1]     ? '1 :
                      (w_s_adj >= w_n_x) ? w_n_x : w_s_adj;

    // Insert slots
    assign w_slot_b = (r_cursor >= w_cnt_s) ? w_cnt_s :
                      (r_cursor <= 0)       ? '0      : r_cursor;
    assign w_slot_a = (r_cursor >= w_cnt_s) ? w_cnt_s :
                      r_cursor[KW-1]        ? '0      : w_cur_p1_k;
    assign w_slot_k = (i_action == ACT_INS_BEFORE) ? w_slot_b : w_slot_a;

    // Shared address stepper: down for an upward shift, up for a downward one
    assign w_step = r_up ? (r_ptr - AW'(1)) : (r_ptr + AW'(1));

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_cursor  = r_cursor;
        n_status  = r_status;
        n_hdl     = r_hdl;
        n_hout    = r_hout;
        n_slot    = r_slot;
        n_ptr     = r_ptr;
        n_last    = r_last;
        n_tgt     = r_tgt;
        n_wa      = r_wa;
        n_pend    = r_pend;
        n_rdone   = r_rdone;
        n_up      = r_up;
        o_mem_ctl = '0;
        o_raddr   = r_ptr;
        o_waddr   = r_wa;
        o_wdata   = i_rdata;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_hdl    = HANDLE_BITS'(i_item_handle);
                    n_status = ST_OK;
                    n_state  = S_LOOK;
                    unique case (i_action) inside
                        ACT_INS_BEFORE, ACT_INS_AFTER: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_slot = w_slot_k[AW-1:0];
                                if (w_slot_k < w_cnt_s) begin
                                    n_ptr   = w_cnt_m1[AW-1:0];
                                    n_last  = w_slot_k[AW-1:0];
                                    n_tgt   = r_count[AW-1:0];
                                    n_up    = 1'b1;
                                    n_pend  = 1'b0;
                                    n_rdone = 1'b0;
                                    n_state = S_SHIFT;
                                end else begin
                                    n_state = S_PUT;
                                end
                            end
                        end
                        ACT_REMOVE: begin
                            if (w_on_item) begin
                                n_state = S_TAKE;
                            end else begin
                                n_status = ST_NO_ITEM;
                            end
                        end
                        ACT_SEEK: begin
                            n_cursor = w_seek_x[KW-1:0];
                        end
                        ACT_ADVANCE: begin
                            if (r_cursor < w_cnt_s) begin
                                n_cursor = w_cur_p1_k;
                            end
                        end
                        ACT_RETREAT: begin
                            if (r_cursor != K_NEG1) begin
                                n_cursor = r_cursor - K_ONE;
                            end
                        end
                        ACT_TO_START: begin
                            n_cursor = K_NEG1;
                        end
                        ACT_TO_END: begin
                            n_cursor = w_cnt_s;
                        end
                        ACT_READ: begin
                            if (!w_on_item) begin
                                n_status = ST_NO_ITEM;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // One entry read and one written per cycle
            S_SHIFT: begin
                o_mem_ctl.rd_en = !r_rdone;
                o_mem_ctl.wr_en = r_pend;
                if (!r_rdone) begin
                    n_pend = 1'b1;
                    n_wa   = r_tgt;
                    n_tgt  = r_ptr;
                    if (r_ptr == r_last) begin
                        n_rdone = 1'b1;
                    end else begin
                        n_ptr = w_step;
                    end
                end else begin
                    n_pend  = 1'b0;
                    n_state = r_up ? S_PUT : S_DONE;
                end
            end

            // Drop the new handle into its slot
            S_PUT: begin
                o_mem_ctl.wr_en = 1'b1;
                o_waddr         = r_slot;
                o_wdata         = r_hdl;
                n_cursor        = {{(KW-AW){1'b0}}, r_slot};
                n_count         = r_count + CW'(1);
                n_hout          = r_hdl;
                n_state         = S_DONE;
            end

            // Fetch the handle being removed
            S_TAKE: begin
                o_mem_ctl.rd_en = 1'b1;
                o_raddr         = w_cur_a;
                n_state         = S_TAKEW;
            end

            S_TAKEW: begin
                n_hout  = i_rdata;
                n_count = w_cnt_m1;
                if (w_cur_p1_k < w_cnt_s) begin
                    n_ptr   = w_cur_p1_k[AW-1:0];
                    n_last  = w_cnt_m1[AW-1:0];
                    n_tgt   = w_cur_a;
                    n_up    = 1'b0;
                    n_pend  = 1'b0;
                    n_rdone = 1'b0;
                    n_state = S_SHIFT;
                end else begin
                    n_state = S_DONE;
                end
            end

            // Read the handle under the cursor
            S_LOOK: begin
                o_mem_ctl.rd_en = w_on_item;
                o_raddr         = w_cur_a;
                n_state         = S_FETCH;
            end

            S_FETCH: begin
                n_hout  = w_on_item ? i_rdata : '0;
                n_state = S_DONE;
            end

            S_DONE: begin
                if (i_res_free) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_cursor <= K_NEG1;
            r_pend   <= 1'b0;
            r_rdone  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_cursor <= n_cursor;
            r_pend   <= n_pend;
            r_rdone  <= n_rdone;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_hdl    <= n_hdl;
        r_hout   <= n_hout;
        r_slot   <= n_slot;
        r_ptr    <= n_ptr;
        r_last   <= n_last;
        r_tgt    <= n_tgt;
        r_wa     <= n_wa;
        r_up     <= n_up;
    end

    // Handshake and result word
    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);

    always_comb begin
        o_result.handle_out   = HANDLE_W'(r_hout);
        o_result.item_valid   = w_on_item;
        o_result.list_length  = w_n_x[LEN_W-1:0];
        o_result.cursor_index = w_c_x[CUR_W-1:0];
        o_result.status       = r_status;
    end

    // Checks
    `CLOH_ASSERT_IMPL(a_rw_apart, i_clk, i_rst_n, o_mem_ctl.wr_en && o_mem_ctl.rd_en, o_waddr != o_raddr, "shift reads and writes the same entry")
    `CLOH_ASSERT_IMPL(a_cursor_range, i_clk, i_rst_n, 1'b1, (r_cursor >= K_NEG1) && (r_cursor <= w_cnt_s), "cursor outside -1..length")
    `CLOH_ASSERT_NEXT(a_one_cmd, i_clk, i_rst_n, i_cmd_valid && o_cmd_ready, !o_cmd_ready, "command taken while one is in work")
    `CLOH_ASSERT_NEXT(a_count_step, i_clk, i_rst_n, 1'b1, (r_count == $past(r_count)) || (r_count == $past(r_count) + CW'(1)) || (r_count == $past(r_count) - CW'(1)), "length moved by more than one")

endmodule

`default_nettype wire

// File: test/cursor_list_of_handles_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_list_of_handles_checker
// Watches the command and result streams of the cursor list, keeps a mirror
// of the handle list and its cursor, and compares every result word with the
// oldest word predicted from the accepted commands.
// ----------------------------------------------------------------------------

module cursor_list_of_handles_checker
    import cloh_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    input  wire logic                 i_s_tready,
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,   // item_handle[31:0], seek_index[41:32]
    input  wire logic [ACTION_W-1:0]  i_s_tuser,   // action[3:0]
    input  wire logic                 i_m_tvalid,
    input  wire logic                 i_m_tready,
    input  wire logic [M_TDATA_W-1:0] i_m_tdata,   // handle_out, item_valid, list_length,
                                                   // cursor_index, status
    output int                        o_fail_count,
    output int                        o_pending
);

    // Mirror of the list state
    logic [HANDLE_W-1:0] handle_mirror [CAPACITY_DEF];
    int                  mirror_len = 0;
    int                  mirror_cur = -1;

    // Result words still owed by the block, oldest first
    t_result owed_words [$];

    // Apply one command to the mirror and build the word it should produce
    task automatic apply_command(input logic [ACTION_W-1:0] act,
                                 input logic [HANDLE_W-1:0] hdl,
                                 input logic signed [SEEK_W-1:0] sk,
                                 output t_result word);
        int                  slot;
        int                  target;
        int                  i;
        logic [HANDLE_W-1:0] hout;
        logic [STATUS_W-1:0] st;
        bit                  removed;
        bit                  on_item;
        hout    = '0;
        st      = ST_OK;
        removed = 1'b0;
        case (act)
            ACT_INS_BEFORE, ACT_INS_AFTER: begin
                if (act == ACT_INS_BEFORE)
                    slot = (mirror_cur <= 0) ? 0 : mirror_cur;
                else
                    slot = (mirror_cur < 0) ? 0 : mirror_cur + 1;
                if (mirror_cur >= mirror_len)
                    slot = mirror_len;
                if (mirror_len >= CAPACITY_DEF) begin
                    st = ST_FULL;
                end else begin
                    for (i = mirror_len; i > slot; i--)
                        handle_mirror[i] = handle_mirror[i-1];
                    handle_mirror[slot] = hdl;
                    mirror_cur = slot;
                    mirror_len++;
                end
            end
            ACT_REMOVE: begin
                if (mirror_cur >= 0 && mirror_cur < mirror_len) begin
                    hout    = handle_mirror[mirror_cur];
                    removed = 1'b1;
                    for (i = mirror_cur; i < mirror_len - 1; i++)
                        handle_mirror[i] = handle_mirror[i+1];
                    mirror_len--;
                end else begin
                    st = ST_NO_ITEM;
                end
            end
            ACT_SEEK: begin
                // negative targets count back from the end, then clamp
                target = int'(sk);
                if (target < 0)
                    target += mirror_len;
                if (target < 0)
                    mirror_cur = -1;
                else if (target >= mirror_len)
                    mirror_cur = mirror_len;
                else
                    mirror_cur = target;
            end
            ACT_ADVANCE: begin
                if (mirror_cur < mirror_len)
                    mirror_cur++;
            end
            ACT_RETREAT: begin
                if (mirror_cur > -1)
                    mirror_cur--;
            end
            ACT_TO_START: mirror_cur = -1;
            ACT_TO_END:   mirror_cur = mirror_len;
            ACT_READ: begin
                if (!(mirror_cur >= 0 && mirror_cur < mirror_len))
                    st = ST_NO_ITEM;
            end
            default: ;  // unused codes leave everything alone
        endcase
        on_item = (mirror_cur >= 0 && mirror_cur < mirror_len);
        if (!removed && on_item)
            hout = handle_mirror[mirror_cur];
        word              = '0;
        word.handle_out   = hout;
        word.item_valid   = on_item;
        word.list_length  = mirror_len[LEN_W-1:0];
        word.cursor_index = mirror_cur[CUR_W-1:0];
        word.status       = st;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            mirror_len = 0;
            mirror_cur = -1;
            owed_words.delete();
        end else begin
            // result side first: a word can never belong to a command taken this edge
            if (i_m_tvalid && i_m_tready) begin
                got = t_result'(i_m_tdata[$bits(t_result)-1:0]);
                if (owed_words.size() == 0) begin
                    $display("%0t: unexpected result word, expected none actual %h",
                             $time, got);
                    o_fail_count++;
                end else begin
                    want = owed_words.pop_front();
                    check_field("handle_out", 32'(want.handle_out), 32'(got.handle_out));
                    check_field("item_valid", 32'(want.item_valid), 32'(got.item_valid));
                    check_field("list_length", 32'(want.list_length),
                                32'(got.list_length));
                    check_field("cursor_index", 32'(want.cursor_index),
                                32'(got.cursor_index));
                    check_field("status", 32'(want.status), 32'(got.status));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                apply_command(i_s_tuser, i_s_tdata[HANDLE_W-1:0],
                              i_s_tdata[HANDLE_W +: SEEK_W], want);
                owed_words.push_back(want);
            end
        end
        o_pending = owed_words.size();
    end

endmodule

// File: test/cursor_list_of_handles_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_list_of_handles_tb
// Drives command words into the cursor list: a directed opening over the
// corner cases, then random phases that fill the store, churn it and drain
// it, with idle bursts on both streams and one long result back-pressure.
// ----------------------------------------------------------------------------

module cursor_list_of_handles_tb
    import cloh_pkg::*;
();

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int RANDOM_ITEMS = 1680;
    localparam int QUIET_ITEMS  = 150;
    localparam int DRAIN_CYCLES = 300;

    // Unused command codes, handled as no-ops by the block
    localparam logic [ACTION_W-1:0] ACT_NOP_LO = ACT_READ + 4'd1;
    localparam logic [ACTION_W-1:0] ACT_NOP_HI = 4'hF;

    typedef enum {MODE_GROW, MODE_CHURN, MODE_SHRINK} t_mode;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cmd_tvalid = 1'b0;
    logic                 cmd_tready;
    logic [S_TDATA_W-1:0] cmd_tdata = '0;
    logic [ACTION_W-1:0]  cmd_tuser = '0;
    logic                 res_tvalid;
    logic                 res_tready = 1'b0;
    logic [M_TDATA_W-1:0] res_tdata;

    int fail_count;
    int pending;
    int sent_count  = 0;
    int random_done = 0;
    int tx_gap_pct  = 20;
    int rx_gap_pct  = 20;
    int cycle_count = 0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    cursor_list_of_handles i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (cmd_tvalid),
        .o_s_tready (cmd_tready),
        .i_s_tdata  (cmd_tdata),
        .i_s_tuser  (cmd_tuser),
        .o_m_tvalid (res_tvalid),
        .i_m_tready (res_tready),
        .o_m_tdata  (res_tdata)
    );

    cursor_list_of_handles_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (cmd_tvalid),
        .i_s_tready   (cmd_tready),
        .i_s_tdata    (cmd_tdata),
        .i_s_tuser    (cmd_tuser),
        .i_m_tvalid   (res_tvalid),
        .i_m_tready   (res_tready),
        .i_m_tdata    (res_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Offer one command word and hold it until taken
    task automatic issue(input logic [ACTION_W-1:0] act, input logic [HANDLE_W-1:0] hdl,
                         input logic [SEEK_W-1:0] sk);
        if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
            cmd_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        cmd_tvalid <= 1'b1;
        cmd_tdata  <= {{(S_TDATA_W-SEEK_W-HANDLE_W){1'b0}}, sk, hdl};
        cmd_tuser  <= act;
        @(posedge clk);
        while (!cmd_tready)
            @(posedge clk);
        sent_count++;
        @(negedge clk);
    endtask

    function automatic logic [HANDLE_W-1:0] rand_handle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        else if (r < 10)
            return '1;
        return $urandom();
    endfunction

    // Mostly near the list range, sometimes anywhere in the 10-bit space
    function automatic logic [SEEK_W-1:0] rand_seek();
        int v;
        if ($urandom_range(0, 3) == 0)
            return SEEK_W'($urandom_range(0, 1023));
        v = int'($urandom_range(0, 520)) - 260;
        return v[SEEK_W-1:0];
    endfunction

    function automatic logic [ACTION_W-1:0] pick_action(input t_mode m);
        int r;
        r = $urandom_range(0, 99);
        case (m)
            MODE_GROW: begin
                if (r < 45)      return ACT_INS_BEFORE;
                else if (r < 90) return ACT_INS_AFTER;
                else if (r < 93) return ACT_SEEK;
                else if (r < 95) return ACT_ADVANCE;
                else if (r < 97) return ACT_RETREAT;
                else if (r < 98) return ACT_READ;
                else if (r < 99) return ACT_TO_START;
                return ACT_TO_END;
            end
            MODE_CHURN: begin
                if (r < 20)      return ACT_INS_BEFORE;
                else if (r < 40) return ACT_INS_AFTER;
                else if (r < 60) return ACT_REMOVE;
                else if (r < 70) return ACT_SEEK;
                else if (r < 78) return ACT_ADVANCE;
                else if (r < 86) return ACT_RETREAT;
                else if (r < 90) return ACT_TO_START;
                else if (r < 93) return ACT_TO_END;
                else if (r < 98) return ACT_READ;
                return ACT_NOP_LO + 4'($urandom_range(0, 6));
            end
            default: begin
                if (r < 5)       return ACT_INS_BEFORE;
                else if (r < 10) return ACT_INS_AFTER;
                else if (r < 60) return ACT_REMOVE;
                else if (r < 75) return ACT_SEEK;
                else if (r < 83) return ACT_ADVANCE;
                else if (r < 90) return ACT_RETREAT;
                else if (r < 94) return ACT_TO_START;
                else if (r < 97) return ACT_TO_END;
                return ACT_READ;
            end
        endcase
    endfunction

    task automatic run_phase(input t_mode m, input int count);
        int                  k;
        logic [ACTION_W-1:0] act;
        for (k = 0; k < count; k++) begin
            if (random_done >= RANDOM_ITEMS - QUIET_ITEMS) begin
                tx_gap_pct = 0;
                rx_gap_pct = 0;
            end else if (random_done % 100 == 0) begin
                // idle density changes in stretches, some with none at all
                tx_gap_pct = 15 * $urandom_range(0, 2);
                rx_gap_pct = 15 * $urandom_range(0, 2);
            end
            act = pick_action(m);
            issue(act, rand_handle(), rand_seek());
            random_done++;
        end
    endtask

    // Result side: random stall bursts plus one long hold-off mid-run
    initial begin
        int stall_left;
        bit long_done;
        stall_left = 0;
        long_done  = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                res_tready <= 1'b0;
                stall_left--;
            end else begin
                res_tready <= 1'b1;
                if (!long_done && sent_count >= 600) begin
                    long_done  = 1'b1;
                    stall_left = 600;
                end else if (rx_gap_pct != 0 && $urandom_range(0, 99) < rx_gap_pct) begin
                    stall_left = $urandom_range(1, 9);
                end
            end
        end
    end

    // Run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty list corners
        issue(ACT_READ, '0, '0);
        issue(ACT_REMOVE, '0, '0);
        issue(ACT_ADVANCE, '0, '0);
        issue(ACT_RETREAT, '0, '0);
        issue(ACT_RETREAT, '0, '0);
        issue(ACT_SEEK, '0, 10'b01_1111_1111);
        issue(ACT_SEEK, '0, 10'b10_0000_0000);
        // Inserts at the ends and in the middle, extreme handles
        issue(ACT_INS_BEFORE, '0, '0);
        issue(ACT_INS_AFTER, '1, '0);
        issue(ACT_INS_BEFORE, 32'hA5A5_5A5A, '0);
        issue(ACT_TO_START, '0, '0);
        issue(ACT_INS_BEFORE, 32'h0123_4567, '0);
        issue(ACT_TO_END, '0, '0);
        issue(ACT_INS_AFTER, 32'h89AB_CDEF, '0);
        // Seek: from the end, clamped low and high, plain index
        issue(ACT_SEEK, '0, '1);
        issue(ACT_SEEK, '0, 10'b10_0000_0000);
        issue(ACT_SEEK, '0, 10'b01_1111_1111);
        issue(ACT_SEEK, '0, 10'd1);
        issue(ACT_READ, '0, '0);
        // Remove leaves the cursor index; remove past the end has no item
        issue(ACT_REMOVE, '0, '0);
        issue(ACT_TO_END, '0, '0);
        issue(ACT_REMOVE, '0, '0);
        issue(ACT_ADVANCE, '0, '0);
        issue(ACT_NOP_HI, '1, '1);
        issue(ACT_NOP_LO, '0, '0);

        // Fill past capacity, churn, drain, fill again, churn to the end
        run_phase(MODE_GROW, 300);
        run_phase(MODE_CHURN, 330);
        run_phase(MODE_SHRINK, 450);
        run_phase(MODE_GROW, 300);
        run_phase(MODE_CHURN, RANDOM_ITEMS - random_done);
        cmd_tvalid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
